[src/nrd_pkg.sv]
// Package for the nibble RLE dictionary decoder.
// Result type, opcode and dictionary type codes, count limits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nrd_pkg;

  localparam int NIB_W   = 4;
  localparam int LEN_W   = 9;
  localparam int CNT_W   = 17;
  localparam int DICT_W  = 64;

  localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  localparam logic [NIB_W-1:0] OP_LONG_ZERO = 4'd0;
  localparam logic [NIB_W-1:0] OP_LIT1      = 4'd1;
  localparam logic [NIB_W-1:0] OP_LIT_DBL   = 4'd2;
  localparam logic [NIB_W-1:0] OP_LIT2      = 4'd3;
  localparam logic [NIB_W-1:0] OP_LIT3      = 4'd4;
  localparam logic [NIB_W-1:0] OP_VAL_RUN   = 4'd5;
  localparam logic [NIB_W-1:0] OP_ZERO_RUN  = 4'd6;
  localparam logic [NIB_W-1:0] OP_DICT_BASE = 4'd7;
  localparam logic [NIB_W-1:0] OP_END       = 4'd15;

  localparam logic [NIB_W-1:0] DT_SINGLE = 4'h1;
  localparam logic [NIB_W-1:0] DT_DOUBLE = 4'h2;
  localparam logic [NIB_W-1:0] DT_ZRUN   = 4'h6;

  localparam logic [LEN_W-1:0] LONG_BIAS  = 9'd19;
  localparam logic [LEN_W-1:0] SHORT_BIAS = 9'd3;

  typedef struct packed {
    logic [NIB_W-1:0] run_value;
    logic [LEN_W-1:0] run_length;
    logic             is_end;
    logic [CNT_W-1:0] end_value;
  } nrd_result_t;

endpackage
`default_nettype wire

[src/nibble_rle_dictionary_decoder_core.sv]
// A result is registered: it appears in the cycle after the nibble that completes it is accepted.
// Throughput: one nibble per cycle; input stalls only while a held result is stalled
// downstream (single result register).
// Reset: synchronous active-low rst_n clears decoder state, dictionary and output valid.
// The decoder state also clears itself after each end request.
`timescale 1ns / 1ps
`default_nettype none
module nibble_rle_dictionary_decoder_core #(
  parameter int OVERFLOW_LIMIT = 8192
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_code_nibble,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_run_value,
  output logic [8:0]       out_run_length,
  output logic             out_is_end,
  output logic [16:0]      out_end_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data
);
  import nrd_pkg::*;

  logic [DICT_W-1:0] dict_r;
  logic              accept;
  logic              res_valid;
  logic              busy;
  nrd_result_t       res;
  nrd_result_t       out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      dict_r <= cfg_data;
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid & ~busy;

  nrd_decode #(
    .OVERFLOW_LIMIT(OVERFLOW_LIMIT)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .nibble    (in_code_nibble),
    .dict      (dict_r),
    .res_valid (res_valid),
    .res       (res)
  );

  nrd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept & res_valid),
    .load_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy      (busy),
    .out_data  (out_data)
  );

  assign out_run_value  = out_data.run_value;
  assign out_run_length = out_data.run_length;
  assign out_is_end     = out_data.is_end;
  assign out_end_value  = out_data.end_value;

endmodule
`default_nettype wire

[src/nrd_decode.sv]
// Opcode/operand state machine: decodes accepted nibbles into run or end results.
// Depends on nrd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrd_decode #(
  parameter int OVERFLOW_LIMIT = 8192
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [3:0]                nibble,
  input  wire logic [63:0]               dict,
  output logic                           res_valid,
  output nrd_pkg::nrd_result_t           res
);
  import nrd_pkg::*;

  typedef enum logic [2:0] {
    PH_OPCODE, PH_LONG_HI, PH_LONG_LO, PH_LITERAL,
    PH_DOUBLE, PH_VRUN_VAL, PH_VRUN_CNT, PH_ZRUN_CNT
  } phase_t;

  localparam logic [CNT_W:0] LIMIT = (CNT_W+1)'(OVERFLOW_LIMIT);

  phase_t           phase_r, phase_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic [3:0]       held_r, held_nxt;
  logic [3:0]       chigh_r, chigh_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             emit;
  logic             end_item;
  logic [3:0]       emit_value;
  logic [LEN_W-1:0] emit_len;
  logic [2:0]       dict_k;
  logic [7:0]       entry;
  logic [CNT_W:0]   count_sum;
  logic [CNT_W:0]   bytes_ext;
  logic [CNT_W:0]   end_sum;
  logic [CNT_W-1:0] end_val;

  assign dict_k = 3'(nibble - OP_DICT_BASE);
  assign entry  = dict[{dict_k, 3'b000} +: 8];

  always_comb begin
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    held_nxt   = held_r;
    chigh_nxt  = chigh_r;
    emit       = 1'b0;
    end_item   = 1'b0;
    emit_value = '0;
    emit_len   = '0;
    unique case (phase_r)
      PH_LONG_HI: begin
        chigh_nxt = nibble;
        phase_nxt = PH_LONG_LO;
      end
      PH_LONG_LO: begin
        phase_nxt = PH_OPCODE;
        emit      = 1'b1;
        emit_len  = {1'b0, chigh_r, nibble} + LONG_BIAS;
      end
      PH_LITERAL: begin
        if (pend_r == 2'd0) begin
          phase_nxt = PH_OPCODE;
        end else begin
          pend_nxt = pend_r - 2'd1;
        end
        emit       = 1'b1;
        emit_value = nibble;
        emit_len   = 9'd1;
      end
      PH_DOUBLE: begin
        phase_nxt  = PH_OPCODE;
        emit       = 1'b1;
        emit_value = nibble;
        emit_len   = 9'd2;
      end
      PH_VRUN_VAL: begin
        held_nxt  = nibble;
        phase_nxt = PH_VRUN_CNT;
      end
      PH_VRUN_CNT: begin
        phase_nxt  = PH_OPCODE;
        emit       = 1'b1;
        emit_value = held_r;
        emit_len   = 9'(nibble) + SHORT_BIAS;
      end
      PH_ZRUN_CNT: begin
        phase_nxt = PH_OPCODE;
        emit      = 1'b1;
        emit_len  = 9'(nibble) + SHORT_BIAS;
      end
      PH_OPCODE: begin
        unique case (nibble)
          OP_LONG_ZERO: phase_nxt = PH_LONG_HI;
          OP_LIT1: begin
            phase_nxt = PH_LITERAL;
            pend_nxt  = 2'd0;
          end
          OP_LIT_DBL: phase_nxt = PH_DOUBLE;
          OP_LIT2: begin
            phase_nxt = PH_LITERAL;
            pend_nxt  = 2'd1;
          end
          OP_LIT3: begin
            phase_nxt = PH_LITERAL;
            pend_nxt  = 2'd2;
          end
          OP_VAL_RUN:  phase_nxt = PH_VRUN_VAL;
          OP_ZERO_RUN: phase_nxt = PH_ZRUN_CNT;
          OP_END:      end_item  = 1'b1;
          default: begin
            unique case (entry[7:4])
              DT_SINGLE: begin
                emit       = 1'b1;
                emit_value = entry[3:0];
                emit_len   = 9'd1;
              end
              DT_DOUBLE: begin
                emit       = 1'b1;
                emit_value = entry[3:0];
                emit_len   = 9'd2;
              end
              DT_ZRUN: begin
                emit     = 1'b1;
                emit_len = 9'(entry[3:0]) + SHORT_BIAS;
              end
              default: emit = 1'b0;
            endcase
          end
        endcase
      end
      default: phase_nxt = PH_OPCODE;
    endcase
  end

  // saturating nibble count
  assign count_sum = {1'b0, count_r} + (CNT_W+1)'(emit_len);

  always_comb begin
    if (end_item) begin
      count_nxt = '0;
    end else if (emit) begin
      count_nxt = count_sum[CNT_W] ? COUNT_MAX : count_sum[CNT_W-1:0];
    end else begin
      count_nxt = count_r;
    end
  end

  assign bytes_ext = {2'b00, count_r[CNT_W-1:1]};
  assign end_sum   = bytes_ext + LIMIT;

  always_comb begin
    if (bytes_ext > LIMIT) begin
      end_val = end_sum[CNT_W] ? COUNT_MAX : end_sum[CNT_W-1:0];
    end else begin
      end_val = '0;
    end
  end

  assign res_valid = emit | end_item;

  always_comb begin
    res            = '0;
    res.run_value  = emit_value;
    res.run_length = emit_len;
    res.is_end     = end_item;
    res.end_value  = end_item ? end_val : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPCODE;
      pend_r  <= '0;
      held_r  <= '0;
      chigh_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      if (end_item) begin
        phase_r <= PH_OPCODE;
        pend_r  <= '0;
        held_r  <= '0;
        chigh_r <= '0;
      end else begin
        phase_r <= phase_nxt;
        pend_r  <= pend_nxt;
        held_r  <= held_nxt;
        chigh_r <= chigh_nxt;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_item |=> phase_r == PH_OPCODE && count_r == '0 && pend_r == '0)
    else $error("decoder state not cleared after end request");

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    end_item |-> !emit && res.run_length == '0 && res.run_value == '0)
    else $error("end result carries run data");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> res.run_length != '0 && res.end_value == '0)
    else $error("run result with zero length or end value");

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !end_item |=> count_r >= $past(count_r))
    else $error("nibble count decreased");
`endif

endmodule
`default_nettype wire

[src/nrd_out_reg.sv]
// Result register between decoder and downstream consumer, with stall handling.
// Depends on nrd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrd_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  nrd_pkg::nrd_result_t      load_data,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic                      busy,
  output nrd_pkg::nrd_result_t      out_data
);
  import nrd_pkg::*;

  logic        valid_r;
  nrd_result_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign busy      = valid_r & out_stall;
  assign out_data  = data_r;

endmodule
`default_nettype wire

[verif/nibble_rle_dictionary_decoder_core_tb.sv]
// Self-checking testbench for nibble_rle_dictionary_decoder_core: directed and random
// nibble streams, random idling on both sides, run predictor checked per field.
// Depends on nrd_pkg and the decoder core RTL.
`timescale 1ns / 1ps
module nibble_rle_dictionary_decoder_core_tb;
  import nrd_pkg::*;

  localparam int OVERFLOW_LIMIT = 8192;
  localparam int CYCLE_LIMIT    = 400_000;
  localparam int MAX_REPORTS    = 10;

  // dictionary types that decode to nothing
  localparam logic [3:0] DT_OTHER_LO = 4'h0;
  localparam logic [3:0] DT_OTHER_HI = 4'hF;

  typedef enum logic [2:0] {
    PH_OPCODE, PH_LONG_HI, PH_LONG_LO, PH_LITERAL,
    PH_DOUBLE, PH_VRUN_VAL, PH_VRUN_CNT, PH_ZRUN_CNT
  } decode_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_code_nibble = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_run_value;
  logic [8:0]  out_run_length;
  logic        out_is_end;
  logic [16:0] out_end_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;

  // decoder model state
  decode_phase_t phase = PH_OPCODE;
  logic [1:0]    lits_left = '0;
  logic [3:0]    held_nib = '0;
  logic [3:0]    count_hi = '0;
  logic [16:0]   nib_total = '0;
  logic [63:0]   dict_model = '0;
  nrd_result_t   expected_runs[$];

  bit in_idle_on = 1'b0;
  bit out_idle_on = 1'b0;
  int hold_off_cycles = 0;
  int recv_wait = 0;
  int items_sent = 0;
  int runs_checked = 0;
  int ends_checked = 0;
  int dict_writes = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  nibble_rle_dictionary_decoder_core #(
    .OVERFLOW_LIMIT(OVERFLOW_LIMIT)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_code_nibble (in_code_nibble),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_run_value  (out_run_value),
    .out_run_length (out_run_length),
    .out_is_end     (out_is_end),
    .out_end_value  (out_end_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void push_run(input logic [3:0] value, input logic [8:0] len);
    nrd_result_t r;
    logic [17:0] sum;
    sum = {1'b0, nib_total} + 18'(len);
    nib_total = (sum > 18'(COUNT_MAX)) ? COUNT_MAX : sum[16:0];
    r.run_value = value;
    r.run_length = len;
    r.is_end = 1'b0;
    r.end_value = '0;
    expected_runs.push_back(r);
  endfunction

  function automatic void push_end();
    nrd_result_t r;
    int bytes_out;
    bytes_out = int'(nib_total >> 1);
    r.run_value = '0;
    r.run_length = '0;
    r.is_end = 1'b1;
    if (bytes_out > OVERFLOW_LIMIT) begin
      if (bytes_out + OVERFLOW_LIMIT > int'(COUNT_MAX)) r.end_value = COUNT_MAX;
      else r.end_value = 17'(bytes_out + OVERFLOW_LIMIT);
    end else begin
      r.end_value = '0;
    end
    expected_runs.push_back(r);
    phase = PH_OPCODE;
    lits_left = '0;
    held_nib = '0;
    count_hi = '0;
    nib_total = '0;
  endfunction

  function automatic void decode_opcode(input logic [3:0] nib);
    int k;
    logic [7:0] entry;
    case (nib)
      OP_LONG_ZERO: phase = PH_LONG_HI;
      OP_LIT1: begin
        phase = PH_LITERAL;
        lits_left = 2'd0;
      end
      OP_LIT_DBL: phase = PH_DOUBLE;
      OP_LIT2: begin
        phase = PH_LITERAL;
        lits_left = 2'd1;
      end
      OP_LIT3: begin
        phase = PH_LITERAL;
        lits_left = 2'd2;
      end
      OP_VAL_RUN: phase = PH_VRUN_VAL;
      OP_ZERO_RUN: phase = PH_ZRUN_CNT;
      OP_END: push_end();
      default: begin
        k = int'(nib - OP_DICT_BASE);
        entry = dict_model[k*8 +: 8];
        if (entry[7:4] == DT_SINGLE) push_run(entry[3:0], 9'd1);
        else if (entry[7:4] == DT_DOUBLE) push_run(entry[3:0], 9'd2);
        else if (entry[7:4] == DT_ZRUN) push_run(4'd0, entry[3:0] + SHORT_BIAS);
      end
    endcase
  endfunction

  function automatic void decode_nibble(input logic [3:0] nib);
    case (phase)
      PH_LONG_HI: begin
        count_hi = nib;
        phase = PH_LONG_LO;
      end
      PH_LONG_LO: begin
        phase = PH_OPCODE;
        push_run(4'd0, {count_hi, nib} + LONG_BIAS);
      end
      PH_LITERAL: begin
        if (lits_left == 2'd0) phase = PH_OPCODE;
        else lits_left = lits_left - 2'd1;
        push_run(nib, 9'd1);
      end
      PH_DOUBLE: begin
        phase = PH_OPCODE;
        push_run(nib, 9'd2);
      end
      PH_VRUN_VAL: begin
        held_nib = nib;
        phase = PH_VRUN_CNT;
      end
      PH_VRUN_CNT: begin
        phase = PH_OPCODE;
        push_run(held_nib, nib + SHORT_BIAS);
      end
      PH_ZRUN_CNT: begin
        phase = PH_OPCODE;
        push_run(4'd0, nib + SHORT_BIAS);
      end
      default: decode_opcode(nib);
    endcase
  endfunction

  function automatic int operand_count(input logic [3:0] op);
    case (op)
      OP_LONG_ZERO, OP_LIT2, OP_VAL_RUN: return 2;
      OP_LIT1, OP_LIT_DBL, OP_ZERO_RUN: return 1;
      OP_LIT3: return 3;
      default: return 0;
    endcase
  endfunction

  function automatic logic [63:0] random_dictionary();
    logic [63:0] d;
    logic [3:0] kind;
    d = '0;
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 3))
        0: kind = DT_SINGLE;
        1: kind = DT_DOUBLE;
        2: kind = DT_ZRUN;
        default: kind = 4'($urandom);
      endcase
      d[k*8 +: 8] = {kind, 4'($urandom)};
    end
    return d;
  endfunction

  task automatic send_nibble(input logic [3:0] nib);
    int gap;
    gap = in_idle_on ? int'($urandom_range(0, 10)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code_nibble <= nib;
    do @(posedge clk); while (in_stall);
    decode_nibble(nib);
    items_sent++;
  endtask

  task automatic send_long_zero(input logic [7:0] count);
    send_nibble(OP_LONG_ZERO);
    send_nibble(count[7:4]);
    send_nibble(count[3:0]);
  endtask

  task automatic send_random_op();
    int pick;
    logic [3:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_nibble(4'($urandom));
    end else if (pick < 13) begin
      send_nibble(OP_END);
    end else begin
      op = 4'($urandom_range(0, 14));
      send_nibble(op);
      repeat (operand_count(op)) send_nibble(4'($urandom));
    end
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dictionary(input logic [63:0] value);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dict_model = value;
    dict_writes++;
  endtask

  task automatic test_directed_opcodes();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    write_dictionary('0);
    send_long_zero(8'h00);
    send_long_zero(8'hFF);
    send_nibble(OP_LIT1);
    send_nibble(4'hF);
    send_nibble(OP_LIT_DBL);
    send_nibble(4'h0);
    send_nibble(OP_LIT2);
    send_nibble(4'hA);
    send_nibble(4'h5);
    send_nibble(OP_LIT3);
    send_nibble(4'hF);
    send_nibble(4'h0);
    send_nibble(4'h1);
    send_nibble(OP_VAL_RUN);
    send_nibble(4'hF);
    send_nibble(4'hF);
    send_nibble(OP_ZERO_RUN);
    send_nibble(4'h0);
    send_nibble(OP_DICT_BASE);
    send_nibble(OP_END);
  endtask

  task automatic test_dictionary_entries();
    write_dictionary({DT_OTHER_HI, 4'hA, DT_DOUBLE, 4'hF, DT_SINGLE, 4'h0,
                      DT_OTHER_LO, 4'h5, DT_ZRUN, 4'h0, DT_ZRUN, 4'hF,
                      DT_DOUBLE, 4'h0, DT_SINGLE, 4'hF});
    for (int k = 0; k < 8; k++) send_nibble(OP_DICT_BASE + 4'(k));
    send_nibble(OP_END);
    write_dictionary('1);
    send_nibble(OP_DICT_BASE);
    send_nibble(OP_DICT_BASE + 4'd7);
    send_nibble(OP_END);
  endtask

  // 16384 nibbles is exactly 8192 bytes; one or two more straddle the limit
  task automatic test_end_threshold();
    for (int extra = 1; extra <= 2; extra++) begin
      repeat (59) send_long_zero(8'hFF);
      send_long_zero(8'd199);
      send_nibble(extra == 1 ? OP_LIT1 : OP_LIT_DBL);
      send_nibble(4'h9);
      send_nibble(OP_END);
    end
  endtask

  task automatic test_count_saturation();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    repeat (479) send_long_zero(8'hFF);
    send_nibble(OP_END);
  endtask

  task automatic test_output_backpressure();
    in_idle_on = 1'b0;
    out_idle_on = 1'b1;
    hold_off_cycles = 150;
    repeat (12) begin
      send_nibble(OP_LIT3);
      repeat (3) send_nibble(4'($urandom));
    end
    send_nibble(OP_END);
  endtask

  task automatic test_random_streams();
    int start_count;
    for (int p = 0; p < 5; p++) begin
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      write_dictionary(random_dictionary());
      start_count = items_sent;
      while (items_sent - start_count < 16) send_random_op();
    end
    send_nibble(OP_END);
  endtask

  // receiver: per-result random hold-off, plus one long forced hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles = hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) recv_wait = out_idle_on ? int'($urandom_range(0, 10)) : 0;
      if (recv_wait > 0) begin
        recv_wait = recv_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    nrd_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_runs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: value %h length %0d end %b count %0d",
                   out_run_value, out_run_length, out_is_end, out_end_value);
      end else begin
        want = expected_runs.pop_front();
        if (out_is_end) ends_checked++;
        else runs_checked++;
        if (out_run_value !== want.run_value || out_run_length !== want.run_length ||
            out_is_end !== want.is_end || out_end_value !== want.end_value) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected value %h length %0d end %b count %0d,",
                     want.run_value, want.run_length, want.is_end, want.end_value,
                     " got value %h length %0d end %b count %0d",
                     out_run_value, out_run_length, out_is_end, out_end_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_runs.size());
      $display("FAIL nibble_rle_dictionary_decoder_core");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_opcodes();
    test_dictionary_entries();
    test_end_threshold();
    test_count_saturation();
    test_output_backpressure();
    test_random_streams();
    wait_for_idle();
    repeat (4) @(posedge clk);
    $display("All opcodes, dictionary types, end threshold, count saturation and a long hold-off");
    $display("%0d nibbles sent, %0d runs and %0d end requests checked,",
             items_sent, runs_checked, ends_checked,
             " %0d dictionary writes, %0d mismatches", dict_writes, mismatch_count);
    if (mismatch_count == 0 && expected_runs.size() == 0) begin
      $display("PASS nibble_rle_dictionary_decoder_core");
    end else begin
      $display("FAIL nibble_rle_dictionary_decoder_core");
    end
    $finish;
  end

endmodule
